>>> rtl/spsu_pkg.sv
// spsu_pkg: shared constants, command codes and bundle types for the
// sequence playback source. No dependencies.
`timescale 1ns / 1ps

package spsu_pkg;

   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int POS_W   = 9;
   localparam int DATA_W  = 64;
   localparam int CMD_W   = 2;
   localparam int CSR_W   = 9;
   localparam int CSR_A_W = 1;
   localparam int STEP_W  = $clog2(DATA_W);

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RANGED = 2'd2;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_LOOP_MODE  = 1'd0;
   localparam logic [CSR_A_W-1:0] CSR_ITEM_COUNT = 1'd1;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> rtl/spsu_table.sv
// spsu_table: entry store, one write port and one registered read port.
// Depends on spsu_pkg.
`timescale 1ns / 1ps

module spsu_table
   import spsu_pkg::*;
(
   input  logic              clock,
   input  tbl_wr_type        wr,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/spsu_divider.sv
// spsu_divider: radix-2 restoring remainder unit, one bit per cycle.
// Depends on spsu_pkg.
`timescale 1ns / 1ps

module spsu_divider
   import spsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DATA_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
         rem_in = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("remainder done without a running division");

   a_no_start_while_run: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !done_ff)
      else $error("done raised while still iterating");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");

endmodule

>>> rtl/sequence_playback_source_unit.sv
// sequence_playback_source_unit: top level, command decode, play position,
// result mapping. Depends on spsu_pkg, spsu_table, spsu_divider.
`timescale 1ns / 1ps
// A load writes the table at the accepting edge; busy stays low. A plain draw,
//   or a ranged draw whose value is in range or whose range is zero, strobes
//   its result through the table read register, then the result register; a
//   ranged draw that needs mapping also waits for the 64 one-bit steps of the remainder unit.
// Throughput: one item at a time; the next start is taken in the strobe cycle.
// The receiver cannot stall: rsp_valid is high for exactly one cycle.
// Reset (synchronous, active high): loop_mode=1, item_count=1, position=0,
//   sequencer idle. Table contents are undefined until loaded.

module sequence_playback_source_unit
   import spsu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [IDX_W-1:0]   req_index,
   input  logic [DATA_W-1:0]  req_value,
   input  logic [DATA_W-1:0]  req_low_bound,
   input  logic [DATA_W-1:0]  req_high_bound,
   // result channel
   output logic               rsp_valid,
   output logic [DATA_W-1:0]  rsp_number,
   output logic               rsp_range_error,
   // register writes
   input  logic               csr_wr_en,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;  // table data is valid
   localparam logic [1:0] ST_DIV   = 2'd2;  // waiting on the remainder unit

   logic [1:0]        state_ff, state_in;
   logic              loop_ff, loop_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              ranged_ff, ranged_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] hi_ff, hi_in;
   logic [DATA_W-1:0] span_ff, span_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_number_ff, rsp_number_in;
   logic              rsp_error_ff, rsp_error_in;

   logic              accept;
   logic              is_draw;
   logic [POS_W-1:0]  n_use;
   logic [POS_W-1:0]  n_last;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              in_range;
   tbl_wr_type        tbl_wr;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign accept  = start && !busy;
   assign is_draw = (req_command == CMD_DRAW) || (req_command == CMD_RANGED);

   // entries in use: zero counts as one, saturate at the table depth
   always_comb begin
      if (count_ff == '0) begin
         n_use = POS_W'(1);
      end else if (count_ff > POS_W'(DEPTH)) begin
         n_use = POS_W'(DEPTH);
      end else begin
         n_use = count_ff;
      end
      n_last = n_use - 1'b1;
   end

   // play position and read address for a draw
   always_comb begin
      pos_in  = pos_ff;
      rd_addr = pos_ff[IDX_W-1:0];
      if (pos_ff < n_use) begin
         pos_in = pos_ff + 1'b1;
      end else if (loop_ff) begin
         rd_addr = '0;
         pos_in  = POS_W'(1);
      end else begin
         rd_addr = n_last[IDX_W-1:0];
      end
      if (!(accept && is_draw)) begin
         pos_in = pos_ff;
      end
      if (csr_wr_en && csr_index == CSR_ITEM_COUNT) begin
         pos_in = '0;
      end
   end

   always_comb begin
      loop_in  = loop_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOOP_MODE:  loop_in  = csr_wr_data[0];
            CSR_ITEM_COUNT: count_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign tbl_wr.en   = accept && (req_command == CMD_LOAD);
   assign tbl_wr.addr = req_index;
   assign tbl_wr.data = req_value;

   assign in_range = (rd_data >= lo_ff) && (rd_data <= hi_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ranged_in     = ranged_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      rsp_valid_in  = 1'b0;
      rsp_number_in = rsp_number_ff;
      rsp_error_in  = rsp_error_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rd_data;
      div_req.divisor  = span_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_draw) begin
               ranged_in = (req_command == CMD_RANGED);
               lo_in     = req_low_bound;
               hi_in     = req_high_bound;
               span_in   = req_high_bound - req_low_bound + 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!ranged_ff || in_range) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = rd_data;
               rsp_error_in  = 1'b0;
               state_in      = ST_IDLE;
            end else if (span_ff == '0) begin
               // full 64-bit range wrapped to zero
               rsp_valid_in  = 1'b1;
               rsp_number_in = lo_ff;
               rsp_error_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = div_rsp.rem + lo_ff;
               rsp_error_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_ff      <= 1'b1;
         count_ff     <= POS_W'(1);
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_ff      <= loop_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ranged_ff     <= ranged_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      span_ff       <= span_in;
      rsp_number_ff <= rsp_number_in;
      rsp_error_ff  <= rsp_error_in;
   end

   spsu_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (accept && is_draw),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spsu_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_number      = rsp_number_ff;
   assign rsp_range_error = rsp_error_ff;

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while an item is still in work");

   a_draw_goes_check: assert property (@(posedge clock) disable iff (reset)
      (accept && is_draw) |=> (state_ff == ST_CHECK))
      else $error("accepted draw did not reach the check step");

   a_error_gives_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_number == lo_ff && ranged_ff))
      else $error("range error without low bound on a ranged draw");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(DEPTH))
      else $error("play position beyond table depth");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for sequence_playback_source_unit.
// Depends on spsu_pkg and the RTL under rtl/; drives commands, predicts and
// checks every drawn number against an in-bench shadow of the table.
`timescale 1ns / 1ps

module tb_top;
   import spsu_pkg::*;

   // code the block must ignore: no result, no state change
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // settle for longer than a mapped ranged draw can take
   localparam int SETTLE_CYCLES = 80;
   localparam int ITEM_TARGET   = 1350;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] low_bound;
      logic [DATA_W-1:0] high_bound;
   } source_cmd_t;

   typedef struct packed {
      logic [DATA_W-1:0] number;
      logic              range_error;
   } draw_result_t;

   // ---------------------------------------------------------------------
   // DUT inputs, all known from time zero, and outputs
   // ---------------------------------------------------------------------
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic [CMD_W-1:0]   req_command     = CMD_LOAD;
   logic [IDX_W-1:0]   req_index       = '0;
   logic [DATA_W-1:0]  req_value       = '0;
   logic [DATA_W-1:0]  req_low_bound   = '0;
   logic [DATA_W-1:0]  req_high_bound  = '0;
   logic               rsp_valid;
   logic [DATA_W-1:0]  rsp_number;
   logic               rsp_range_error;
   logic               csr_wr_en       = 1'b0;
   logic [CSR_A_W-1:0] csr_index       = CSR_LOOP_MODE;
   logic [CSR_W-1:0]   csr_wr_data     = '0;

   sequence_playback_source_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_low_bound   (req_low_bound),
      .req_high_bound  (req_high_bound),
      .rsp_valid       (rsp_valid),
      .rsp_number      (rsp_number),
      .rsp_range_error (rsp_range_error),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: table, play position and both registers.
   // Updated when an item is accepted (driver) or a register is written.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0] shadow_tbl [DEPTH];
   logic [POS_W-1:0]  play_pos    = '0;
   logic              wrap_mode   = 1'b1;
   logic [CSR_W-1:0]  entry_count = 9'd1;

   source_cmd_t  cmd_backlog [$];   // items waiting for the driver
   draw_result_t due_results [$];   // predicted numbers, oldest first
   source_cmd_t  in_flight;
   draw_result_t oldest_due;

   // stimulus side bookkeeping: which entries hold loaded data
   bit loaded [DEPTH];

   int items_queued = 0;
   int items_taken  = 0;
   int n_loads      = 0;
   int n_draws      = 0;
   int n_ranged     = 0;
   int n_flagged    = 0;
   int n_checked    = 0;
   int n_reg_writes = 0;
   int n_errors     = 0;

   // item_count as the block uses it: zero acts as one, saturates at DEPTH
   function automatic int live_count();
      if (entry_count == 0) return 1;
      if (entry_count > DEPTH) return DEPTH;
      return int'(entry_count);
   endfunction

   // Play one entry and move the position. Past the end: wrap to entry
   // zero in loop mode, otherwise stick on the last entry in use.
   function automatic logic [DATA_W-1:0] take_entry();
      int                n;
      logic [DATA_W-1:0] v;
      n = live_count();
      if (play_pos < n) begin
         v = shadow_tbl[play_pos];
         play_pos = play_pos + 1'b1;
      end else if (wrap_mode) begin
         v = shadow_tbl[0];
         play_pos = 9'd1;
      end else begin
         v = shadow_tbl[n-1];
      end
      return v;
   endfunction

   task automatic apply_command(input source_cmd_t c);
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] span;
      draw_result_t      r;
      case (c.command)
         CMD_LOAD: begin
            shadow_tbl[c.index] = c.value;
            n_loads++;
         end
         CMD_DRAW: begin
            r.number      = take_entry();
            r.range_error = 1'b0;
            due_results.push_back(r);
            n_draws++;
         end
         CMD_RANGED: begin
            v             = take_entry();
            span          = c.high_bound - c.low_bound + 1'b1;  // wraps in 64 bits
            r.range_error = 1'b0;
            if (v >= c.low_bound && v <= c.high_bound) begin
               r.number = v;                                    // already in range
            end else if (span == '0) begin
               r.number      = c.low_bound;                     // full-width span
               r.range_error = 1'b1;
               n_flagged++;
            end else begin
               r.number = (v % span) + c.low_bound;             // inverted bounds land here too
            end
            due_results.push_back(r);
            n_ranged++;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: one item on the req_ ports at a time, held until taken.
   // About 14 in 100 free slots stay empty, none while items_taken is 400 to 699.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_command(in_flight);
            items_taken++;
         end
         if (!start || !busy) begin
            if (cmd_backlog.size() != 0 &&
                ((items_taken >= 400 && items_taken < 700) ||
                 $urandom_range(0, 99) >= 14)) begin
               in_flight = cmd_backlog.pop_front();
               start          <= 1'b1;
               req_command    <= in_flight.command;
               req_index      <= in_flight.index;
               req_value      <= in_flight.value;
               req_low_bound  <= in_flight.low_bound;
               req_high_bound <= in_flight.high_bound;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed result is matched against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual number %h range_error %b",
                     $time, rsp_number, rsp_range_error);
            n_errors++;
         end else begin
            oldest_due = due_results.pop_front();
            n_checked++;
            if (rsp_number !== oldest_due.number) begin
               $display("%0t: number mismatch: expected %h, actual %h",
                        $time, oldest_due.number, rsp_number);
               n_errors++;
            end
            if (rsp_range_error !== oldest_due.range_error) begin
               $display("%0t: range_error mismatch: expected %b, actual %b",
                        $time, oldest_due.range_error, rsp_range_error);
               n_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi);
      source_cmd_t c;
      c = '{command: cmd, index: idx, value: val, low_bound: lo, high_bound: hi};
      cmd_backlog.push_back(c);
      if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
      if (cmd != CMD_UNUSED) items_queued++;
   endtask

   // Block is idle once nothing is queued, held or due; loads give no
   // result, so settle for a full mapped-draw latency on top.
   task automatic wait_idle();
      while (cmd_backlog.size() != 0 || start || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input logic [CSR_W-1:0] data);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CSR_W'($urandom_range(0, 511));
      if (idx == CSR_LOOP_MODE) begin
         wrap_mode = data[0];
      end else begin
         entry_count = data;
         play_pos    = '0;     // a count write rewinds playback
      end
      n_reg_writes++;
   endtask

   // biased toward the corners of a 64-bit word
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DATA_W'($urandom_range(0, 15));
         3:       return {1'b1, 31'($urandom), 32'($urandom)};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int                phase;
      int                k;
      int                sel;
      logic [CSR_W-1:0]  cnt;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset settings are loop on, one entry in use ---
      queue_item(CMD_LOAD, 8'd0, '1, '0, '0);
      queue_item(CMD_DRAW, '0, '0, '0, '0);
      queue_item(CMD_DRAW, '0, '0, '0, '0);                   // wraps back to entry 0
      queue_item(CMD_RANGED, '0, '0, 64'd1, 64'd0);           // span wraps to zero
      queue_item(CMD_RANGED, '0, '0, 64'd5, '1);              // value in range, passes
      queue_item(CMD_RANGED, '0, '0, 64'd100, 64'd10);        // inverted bounds
      queue_item(CMD_RANGED, '0, '0, '1, {{63{1'b1}}, 1'b0}); // zero span at the top
      queue_item(CMD_LOAD, 8'd0, '0, '1, '1);
      queue_item(CMD_RANGED, '0, '0, 64'd1, 64'd1);           // span of one
      queue_item(CMD_RANGED, '0, '0, 64'd3, 64'd9);
      queue_item(CMD_RANGED, '0, '0, '0, '1);                 // whole range, value 0
      queue_item(CMD_UNUSED, '1, '1, '1, '1);                 // ignored code
      queue_item(CMD_LOAD, 8'd255, {32{2'b01}}, '0, '0);      // top index

      // four entries, no looping: the last one repeats
      write_reg(CSR_ITEM_COUNT, 9'd4);
      write_reg(CSR_LOOP_MODE, 9'h1FE);
      queue_item(CMD_LOAD, 8'd1, {32{2'b10}}, '0, '0);
      queue_item(CMD_LOAD, 8'd2, {1'b1, 63'd0}, '0, '0);
      queue_item(CMD_LOAD, 8'd3, 64'd1, '0, '0);
      for (k = 0; k < 6; k++) queue_item(CMD_DRAW, '0, '0, '0, '0);
      queue_item(CMD_RANGED, '0, '0, '1, '1);

      // count zero behaves as one
      write_reg(CSR_ITEM_COUNT, 9'd0);
      queue_item(CMD_DRAW, '0, '0, '0, '0);
      queue_item(CMD_DRAW, '0, '0, '0, '0);
      write_reg(CSR_LOOP_MODE, 9'h001);

      // --- random phases: new settings, fill any unloaded entries in use,
      //     then a mix of loads, draws, ranged draws and the odd junk code ---
      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         if (phase == 1) begin
            cnt = 9'h1FF;                 // above DEPTH, saturates
         end else if (phase == 4) begin
            cnt = CSR_W'(DEPTH);
         end else begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)      cnt = CSR_W'($urandom_range(1, 8));
            else if (sel == 6) cnt = '0;
            else if (sel == 7) cnt = CSR_W'($urandom_range(257, 511));
            else if (sel == 8) cnt = CSR_W'($urandom_range(9, 256));
            else               cnt = CSR_W'($urandom_range(1, 3));
         end
         write_reg(CSR_LOOP_MODE, CSR_W'($urandom_range(0, 511)));
         write_reg(CSR_ITEM_COUNT, cnt);

         // a draw may touch any entry below the count in use
         for (k = 0; k < live_count(); k++)
            if (!loaded[k]) queue_item(CMD_LOAD, IDX_W'(k), pick_word(), '0, '0);

         for (k = 0; k < 100; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
               queue_item(CMD_LOAD, IDX_W'($urandom_range(0, 255)), pick_word(),
                          pick_word(), pick_word());
            end else if (sel < 62) begin
               queue_item(CMD_DRAW, IDX_W'($urandom), pick_word(), pick_word(), pick_word());
            end else if (sel < 95) begin
               lo = pick_word();
               case ($urandom_range(0, 5))
                  0:       begin lo = '0; hi = '1; end
                  1:       hi = lo - 1'b1;                        // full span
                  2:       hi = lo + DATA_W'($urandom_range(0, 20));
                  3:       begin hi = pick_word(); if (hi > lo) {lo, hi} = {hi, lo}; end
                  4:       begin lo = DATA_W'($urandom_range(0, 7)); hi = pick_word(); end
                  default: hi = pick_word();
               endcase
               queue_item(CMD_RANGED, IDX_W'($urandom), pick_word(), lo, hi);
            end else begin
               queue_item(CMD_UNUSED, IDX_W'($urandom), pick_word(), pick_word(), pick_word());
            end
         end
         phase++;
      end

      wait_idle();
      $display("Checked %0d results: %0d plain draws, %0d ranged draws (%0d zero-span)",
               n_checked, n_draws, n_ranged, n_flagged);
      $display("Also %0d loads and %0d register writes over %0d random phases",
               n_loads, n_reg_writes, phase);
      if (n_errors == 0)
         $display("sequence_playback_source_unit test passed");
      else
         $display("sequence_playback_source_unit test failed");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Timeout with %0d items pending and %0d results due",
               cmd_backlog.size(), due_results.size());
      $display("sequence_playback_source_unit test failed");
      $finish;
   end

endmodule
